// ===== design/ifcp_pkg.sv =====
// Shared types and constants for the IRC formatting code parser.
// Used by every module of the block; no dependencies.
package ifcp_pkg;

  localparam int unsigned CharW  = 21;
  localparam int unsigned ColorW = 7;
  localparam int unsigned DigitW = 4;
  localparam int unsigned AccW   = 11; // wide enough for 127 * 10 + 9

  localparam logic [CharW-1:0] ChBold      = 21'h000002;
  localparam logic [CharW-1:0] ChColor     = 21'h000003;
  localparam logic [CharW-1:0] ChPlain     = 21'h00000F;
  localparam logic [CharW-1:0] ChReverse   = 21'h000016;
  localparam logic [CharW-1:0] ChItalic    = 21'h00001D;
  localparam logic [CharW-1:0] ChUnderline = 21'h00001F;
  localparam logic [CharW-1:0] ChComma     = 21'h00002C;
  localparam logic [CharW-1:0] ChZero      = 21'h000030;
  localparam logic [CharW-1:0] ChNine      = 21'h000039;

  localparam logic [ColorW-1:0] ColorSat        = 7'd127;
  localparam logic [ColorW-1:0] DefaultColorRst = 7'd99;
  localparam logic [ColorW-1:0] HighestColorRst = 7'd15;

  typedef enum logic [0:0] {
    CFG_DEFAULT_COLOR = 1'b0,
    CFG_HIGHEST_COLOR = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_TEXT,
    KIND_BOLD,
    KIND_ITALIC,
    KIND_UNDERLINE,
    KIND_REVERSE,
    KIND_PLAIN,
    KIND_COLOR
  } kind_e;

  // Classified character passed from the front end to the back end
  typedef struct packed {
    logic [CharW-1:0]  char_code;
    logic              line_last;
    kind_e             kind;
    logic              is_digit;
    logic              is_comma;
    logic [DigitW-1:0] digit;
  } item_t;

  typedef struct packed {
    logic              text_valid;
    logic [CharW-1:0]  text_char;
    logic              is_bold;
    logic              is_italic;
    logic              is_underline;
    logic              is_reverse;
    logic [ColorW-1:0] fore_color;
    logic [ColorW-1:0] back_color;
    logic              segment_start;
    logic              end_of_line;
    logic              run_last;
  } result_t;

endpackage

// ===== design/ifcp_front.sv =====
// Front end: accepts characters from the input stream and classifies them.
// Depends on ifcp_pkg; feeds ifcp_fifo.
module ifcp_front (
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [ifcp_pkg::CharW-1:0] char_i,
  input  logic                      last_i,
  input  logic                      full_i,
  output logic                      push_o,
  output ifcp_pkg::item_t           item_o
);

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    item_o           = '0;
    item_o.char_code = char_i;
    item_o.line_last = last_i;
    item_o.is_digit  = (char_i >= ifcp_pkg::ChZero) && (char_i <= ifcp_pkg::ChNine);
    item_o.is_comma  = (char_i == ifcp_pkg::ChComma);
    item_o.digit     = char_i[ifcp_pkg::DigitW-1:0];
    unique case (char_i)
      ifcp_pkg::ChBold:      item_o.kind = ifcp_pkg::KIND_BOLD;
      ifcp_pkg::ChItalic:    item_o.kind = ifcp_pkg::KIND_ITALIC;
      ifcp_pkg::ChUnderline: item_o.kind = ifcp_pkg::KIND_UNDERLINE;
      ifcp_pkg::ChReverse:   item_o.kind = ifcp_pkg::KIND_REVERSE;
      ifcp_pkg::ChPlain:     item_o.kind = ifcp_pkg::KIND_PLAIN;
      ifcp_pkg::ChColor:     item_o.kind = ifcp_pkg::KIND_COLOR;
      default:               item_o.kind = ifcp_pkg::KIND_TEXT;
    endcase
  end

endmodule

// ===== design/ifcp_fifo.sv =====
// Two-entry queue of classified characters between front and back end.
// Depends on ifcp_pkg.
module ifcp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ifcp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ifcp_pkg::item_t item_o
);

  ifcp_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/ifcp_back.sv =====
// Back end: attribute and colour-parse state, result generation and a
// two-result output buffer. Depends on ifcp_pkg; fed by ifcp_fifo.
module ifcp_back #(
  parameter int unsigned MAX_COLOR_DIGITS = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  ifcp_pkg::item_t             item_i,
  output logic                        item_pop_o,
  input  logic [ifcp_pkg::ColorW-1:0] default_color_i,
  input  logic [ifcp_pkg::ColorW-1:0] highest_color_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ifcp_pkg::result_t           out_o
);

  localparam int unsigned CntW = $clog2(MAX_COLOR_DIGITS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_COLOR_DIGITS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FG,
    PH_COMMA,
    PH_BG
  } phase_e;

  typedef struct packed {
    logic                        bold;
    logic                        italic;
    logic                        underline;
    logic                        reverse;
    logic [ifcp_pkg::ColorW-1:0] fore;
    logic [ifcp_pkg::ColorW-1:0] back;
    phase_e                      phase;
    logic [ifcp_pkg::ColorW-1:0] acc;
    logic [CntW-1:0]             cnt;
    logic                        after;
  } state_t;

  localparam state_t StateRst = '{
    bold:      1'b0,
    italic:    1'b0,
    underline: 1'b0,
    reverse:   1'b0,
    fore:      ifcp_pkg::DefaultColorRst,
    back:      ifcp_pkg::DefaultColorRst,
    phase:     PH_IDLE,
    acc:       '0,
    cnt:       '0,
    after:     1'b1
  };

  state_t            st_q, st_d;
  ifcp_pkg::result_t buf_q [2];
  ifcp_pkg::result_t buf_d [2];
  logic [1:0]        ocnt_q, ocnt_d;

  ifcp_pkg::result_t res [2];
  logic [1:0]        nres;
  logic              take;

  function automatic logic [ifcp_pkg::ColorW-1:0] acc_next(
    input logic [ifcp_pkg::ColorW-1:0] acc,
    input logic [ifcp_pkg::DigitW-1:0] d
  );
    logic [ifcp_pkg::AccW-1:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {7'b0, d};
    return (v > ifcp_pkg::AccW'(ifcp_pkg::ColorSat)) ? ifcp_pkg::ColorSat
                                                      : v[ifcp_pkg::ColorW-1:0];
  endfunction

  function automatic ifcp_pkg::result_t make_res(
    input state_t                      s,
    input logic                        valid,
    input logic [ifcp_pkg::CharW-1:0]  ch,
    input logic                        seg
  );
    ifcp_pkg::result_t r;
    r               = '0;
    r.text_valid    = valid;
    r.text_char     = ch;
    r.is_bold       = s.bold;
    r.is_italic     = s.italic;
    r.is_underline  = s.underline;
    r.is_reverse    = s.reverse;
    r.fore_color    = s.fore;
    r.back_color    = s.back;
    r.segment_start = seg;
    return r;
  endfunction

  // A new item may enter only when everything but what leaves this cycle is drained
  assign take        = out_valid_o && out_ready_i;
  assign item_pop_o  = item_valid_i && ((ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && out_ready_i));
  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_o       = buf_q[0];

  always_comb begin
    logic normal;
    state_t s;
    s      = st_q;
    normal = 1'b0;
    nres   = 2'd0;
    res[0] = '0;
    res[1] = '0;

    unique case (st_q.phase)
      PH_FG: begin
        if (item_i.is_digit && (st_q.cnt < CntMax)) begin
          s.acc = acc_next(st_q.acc, item_i.digit);
          s.cnt = st_q.cnt + CntW'(1);
        end else if (st_q.cnt == '0) begin
          s.fore  = default_color_i;
          s.back  = default_color_i;
          s.phase = PH_IDLE;
          normal  = 1'b1;
        end else begin
          s.fore = (st_q.acc > highest_color_i) ? default_color_i : st_q.acc;
          if (item_i.is_comma) begin
            s.phase = PH_COMMA;
          end else begin
            s.phase = PH_IDLE;
            normal  = 1'b1;
          end
        end
      end
      PH_COMMA: begin
        if (item_i.is_digit) begin
          s.acc   = {3'b0, item_i.digit};
          s.cnt   = CntW'(1);
          s.phase = PH_BG;
        end else begin
          // held comma was plain text after all
          res[0]  = make_res(s, 1'b1, ifcp_pkg::ChComma, s.after);
          nres    = 2'd1;
          s.after = 1'b0;
          s.phase = PH_IDLE;
          normal  = 1'b1;
        end
      end
      PH_BG: begin
        if (item_i.is_digit && (st_q.cnt < CntMax)) begin
          s.acc = acc_next(st_q.acc, item_i.digit);
          s.cnt = st_q.cnt + CntW'(1);
        end else begin
          s.back  = (st_q.acc > highest_color_i) ? default_color_i : st_q.acc;
          s.phase = PH_IDLE;
          normal  = 1'b1;
        end
      end
      default: begin
        normal = 1'b1;
      end
    endcase

    if (normal) begin
      unique case (item_i.kind)
        ifcp_pkg::KIND_BOLD: begin
          s.bold  = !s.bold;
          s.after = 1'b1;
        end
        ifcp_pkg::KIND_ITALIC: begin
          s.italic = !s.italic;
          s.after  = 1'b1;
        end
        ifcp_pkg::KIND_UNDERLINE: begin
          s.underline = !s.underline;
          s.after     = 1'b1;
        end
        ifcp_pkg::KIND_REVERSE: begin
          s.reverse = !s.reverse;
          s.after   = 1'b1;
        end
        ifcp_pkg::KIND_PLAIN: begin
          s.bold      = 1'b0;
          s.italic    = 1'b0;
          s.underline = 1'b0;
          s.reverse   = 1'b0;
          s.fore      = default_color_i;
          s.back      = default_color_i;
          s.after     = 1'b1;
        end
        ifcp_pkg::KIND_COLOR: begin
          s.phase = PH_FG;
          s.acc   = '0;
          s.cnt   = '0;
          s.after = 1'b1;
        end
        default: begin
          if (nres == 2'd0) begin
            res[0] = make_res(s, 1'b1, item_i.char_code, s.after);
          end else begin
            res[1] = make_res(s, 1'b1, item_i.char_code, s.after);
          end
          nres    = nres + 2'd1;
          s.after = 1'b0;
        end
      endcase
    end

    if (item_i.line_last) begin
      // comma still held at line end goes out as text
      if (s.phase == PH_COMMA) begin
        res[0]  = make_res(s, 1'b1, ifcp_pkg::ChComma, s.after);
        nres    = 2'd1;
      end
      if (nres == 2'd0) begin
        res[0] = make_res(s, 1'b0, '0, 1'b0);
        nres   = 2'd1;
      end
      if (nres == 2'd1) begin
        res[0].end_of_line = 1'b1;
      end else begin
        res[1].end_of_line = 1'b1;
      end
      s           = '0;
      s.fore      = default_color_i;
      s.back      = default_color_i;
      s.phase     = PH_IDLE;
      s.after     = 1'b1;
    end

    if (nres == 2'd1) begin
      res[0].run_last = 1'b1;
    end else if (nres == 2'd2) begin
      res[1].run_last = 1'b1;
    end

    st_d = item_pop_o ? s : st_q;
  end

  always_comb begin
    buf_d[0] = buf_q[0];
    buf_d[1] = buf_q[1];
    ocnt_d   = ocnt_q;
    if (item_pop_o && (nres != 2'd0)) begin
      buf_d[0] = res[0];
      buf_d[1] = res[1];
      ocnt_d   = nres;
    end else if (take) begin
      buf_d[0] = buf_q[1];
      ocnt_d   = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StateRst;
      ocnt_q <= 2'd0;
    end else begin
      st_q   <= st_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q[0] <= buf_d[0];
    buf_q[1] <= buf_d[1];
  end

endmodule

// ===== design/irc_format_code_parser.sv =====
// Top level of the IRC formatting code parser: configuration registers and
// the front end, queue and back end. Depends on ifcp_pkg and its submodules.
//
// Usage:
//   s_axis carries one character per transaction: tdata[20:0] is the code
//   point, tlast marks the last character of a line. m_axis carries the
//   results: text character and attributes in tdata, text_valid and
//   segment_start in tuser, tlast on the final result of a line.
//   Each input gives zero, one or two results; tdata[39] marks the last
//   result of an input. A line's last character always gives a result.
//   cfg writes default_color (index 0) or highest_color (index 1), always
//   ready; the user must write it only while the block idles (unenforced).
// Timing:
//   One character per cycle while the output is ready; an input that
//   yields two results holds the back end while its second result drains.
//   An input is registered in the queue, then its results in the output
//   buffer. An output stall (or a second result draining) still takes one
//   input into the queue, which then fills and s_axis_tready drops.
// Reset:
//   Attributes clear, colours become the reset default, queue and output
//   buffer empty. No clearing pass is needed.
module irc_format_code_parser #(
  parameter int unsigned MAX_COLOR_DIGITS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // char_code [20:0], zero padding [23:21]
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // text_char [20:0], is_bold [21], is_italic [22], is_underline [23],
  // is_reverse [24], fore_color [31:25], back_color [38:32], run_last [39]
  output logic [39:0] m_axis_tdata,
  // text_valid [0], segment_start [1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_addr_i,
  input  logic [6:0]  cfg_data_i
);

  logic [ifcp_pkg::ColorW-1:0] default_color_q, highest_color_q;
  logic                        push, full, pop, q_valid;
  ifcp_pkg::item_t             f_item, q_item;
  ifcp_pkg::result_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_color_q <= ifcp_pkg::DefaultColorRst;
      highest_color_q <= ifcp_pkg::HighestColorRst;
    end else if (cfg_valid_i) begin
      unique case (ifcp_pkg::cfg_idx_e'(cfg_addr_i))
        ifcp_pkg::CFG_DEFAULT_COLOR: default_color_q <= cfg_data_i;
        ifcp_pkg::CFG_HIGHEST_COLOR: highest_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ifcp_front u_front (
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .char_i  (s_axis_tdata[ifcp_pkg::CharW-1:0]),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .push_o  (push),
    .item_o  (f_item)
  );

  ifcp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ifcp_back #(
    .MAX_COLOR_DIGITS (MAX_COLOR_DIGITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (q_valid),
    .item_i          (q_item),
    .item_pop_o      (pop),
    .default_color_i (default_color_q),
    .highest_color_i (highest_color_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_o           (res)
  );

  assign m_axis_tdata = {res.run_last, res.back_color, res.fore_color, res.is_reverse,
                         res.is_underline, res.is_italic, res.is_bold, res.text_char};
  assign m_axis_tuser = {res.segment_start, res.text_valid};
  assign m_axis_tlast = res.end_of_line;

endmodule

// ===== tb/sv/irc_format_code_parser_test.sv =====
// Self-checking testbench for irc_format_code_parser: directed rows, then random chat lines
// under several color settings, checked against an in-bench predictor or typed results.
// Depends on ifcp_pkg and the irc_format_code_parser RTL.
`timescale 1ns / 1ps

module irc_format_code_parser_test;

  localparam int unsigned MaxDigits  = 2;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned PhaseItems = 180;
  localparam int unsigned NumPhases  = 5;

  typedef enum logic [1:0] {CP_IDLE, CP_FORE, CP_COMMA, CP_BACK} color_phase_e;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_SLOW} rx_mode_e;

  typedef struct {
    logic [ifcp_pkg::CharW-1:0] ch;
    logic                       last;
    logic                       typed;
    ifcp_pkg::result_t          res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_addr_i = '0;
  logic [6:0]  cfg_data_i = '0;

  irc_format_code_parser #(
    .MAX_COLOR_DIGITS(MaxDigits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Predictor state
  logic [ifcp_pkg::ColorW-1:0] default_cfg = ifcp_pkg::DefaultColorRst;
  logic [ifcp_pkg::ColorW-1:0] highest_cfg = ifcp_pkg::HighestColorRst;
  logic                        bold_q, italic_q, underline_q, reverse_q;
  logic [ifcp_pkg::ColorW-1:0] fore_q, back_q;
  color_phase_e                phase_q;
  logic [ifcp_pkg::ColorW-1:0] acc_q;
  int unsigned                 cnt_q;
  logic                        fresh_q;

  ifcp_pkg::result_t step_q[$];
  ifcp_pkg::result_t pending_results[$];
  int                fail_cnt = 0;

  // Set by the driver along with each character; read when it is accepted
  logic              typed_on = 1'b0;
  ifcp_pkg::result_t typed_res = '0;
  int                burst_left = 0;

  function automatic void clear_line_state();
    bold_q      = 1'b0;
    italic_q    = 1'b0;
    underline_q = 1'b0;
    reverse_q   = 1'b0;
    fore_q      = default_cfg;
    back_q      = default_cfg;
    phase_q     = CP_IDLE;
    acc_q       = '0;
    cnt_q       = 0;
    fresh_q     = 1'b1;
  endfunction

  function automatic void put_res(logic tv, logic [ifcp_pkg::CharW-1:0] ch, logic seg);
    ifcp_pkg::result_t r;
    r               = '0;
    r.text_valid    = tv;
    r.text_char     = ch;
    r.is_bold       = bold_q;
    r.is_italic     = italic_q;
    r.is_underline  = underline_q;
    r.is_reverse    = reverse_q;
    r.fore_color    = fore_q;
    r.back_color    = back_q;
    r.segment_start = seg;
    step_q.push_back(r);
  endfunction

  function automatic void put_text(logic [ifcp_pkg::CharW-1:0] ch);
    put_res(1'b1, ch, fresh_q);
    fresh_q = 1'b0;
  endfunction

  function automatic logic [ifcp_pkg::ColorW-1:0] range_color(
    logic [ifcp_pkg::ColorW-1:0] v);
    return (v > highest_cfg) ? default_cfg : v;
  endfunction

  function automatic void push_digit(logic [3:0] dig);
    int unsigned v;
    v     = acc_q * 10 + dig;
    acc_q = (v > 127) ? ifcp_pkg::ColorSat : v[ifcp_pkg::ColorW-1:0];
    if (cnt_q < 3) cnt_q++;
  endfunction

  // Formatting decode of one character; results land in step_q
  function automatic void decode_char(logic [ifcp_pkg::CharW-1:0] c, logic last);
    logic       is_dig;
    logic [3:0] dig;
    logic       normal;
    int         n;
    is_dig = (c >= ifcp_pkg::ChZero) && (c <= ifcp_pkg::ChNine);
    dig    = is_dig ? c[3:0] : 4'd0;
    normal = 1'b0;
    step_q.delete();
    case (phase_q)
      CP_FORE: begin
        if (is_dig && cnt_q < MaxDigits) begin
          push_digit(dig);
        end else if (cnt_q == 0) begin
          fore_q  = default_cfg;
          back_q  = default_cfg;
          phase_q = CP_IDLE;
          normal  = 1'b1;
        end else begin
          fore_q = range_color(acc_q);
          if (c == ifcp_pkg::ChComma) begin
            phase_q = CP_COMMA;
          end else begin
            phase_q = CP_IDLE;
            normal  = 1'b1;
          end
        end
      end
      CP_COMMA: begin
        if (is_dig) begin
          acc_q = '0;
          cnt_q = 0;
          push_digit(dig);
          phase_q = CP_BACK;
        end else begin
          // comma was not part of the code: it goes out as text first
          put_text(ifcp_pkg::ChComma);
          phase_q = CP_IDLE;
          normal  = 1'b1;
        end
      end
      CP_BACK: begin
        if (is_dig && cnt_q < MaxDigits) begin
          push_digit(dig);
        end else begin
          back_q  = range_color(acc_q);
          phase_q = CP_IDLE;
          normal  = 1'b1;
        end
      end
      default: normal = 1'b1;
    endcase

    if (normal) begin
      case (c)
        ifcp_pkg::ChBold: begin
          bold_q  = ~bold_q;
          fresh_q = 1'b1;
        end
        ifcp_pkg::ChItalic: begin
          italic_q = ~italic_q;
          fresh_q  = 1'b1;
        end
        ifcp_pkg::ChUnderline: begin
          underline_q = ~underline_q;
          fresh_q     = 1'b1;
        end
        ifcp_pkg::ChReverse: begin
          reverse_q = ~reverse_q;
          fresh_q   = 1'b1;
        end
        ifcp_pkg::ChPlain: begin
          bold_q      = 1'b0;
          italic_q    = 1'b0;
          underline_q = 1'b0;
          reverse_q   = 1'b0;
          fore_q      = default_cfg;
          back_q      = default_cfg;
          fresh_q     = 1'b1;
        end
        ifcp_pkg::ChColor: begin
          phase_q = CP_FORE;
          acc_q   = '0;
          cnt_q   = 0;
          fresh_q = 1'b1;
        end
        default: put_text(c);
      endcase
    end

    if (last) begin
      if (phase_q == CP_COMMA) put_text(ifcp_pkg::ChComma);
      // attributes shown are the ones before the line-end clear
      if (step_q.size() == 0) put_res(1'b0, '0, 1'b0);
      n = step_q.size();
      step_q[n-1].end_of_line = 1'b1;
      clear_line_state();
    end
    n = step_q.size();
    if (n > 0) step_q[n-1].run_last = 1'b1;
  endfunction

  function automatic ifcp_pkg::result_t typed_result(
    logic tv, logic [ifcp_pkg::CharW-1:0] ch, logic b, logic i, logic u, logic r,
    logic [ifcp_pkg::ColorW-1:0] fg, logic [ifcp_pkg::ColorW-1:0] bg, logic seg,
    logic eol);
    ifcp_pkg::result_t res;
    res               = '0;
    res.text_valid    = tv;
    res.text_char     = ch;
    res.is_bold       = b;
    res.is_italic     = i;
    res.is_underline  = u;
    res.is_reverse    = r;
    res.fore_color    = fg;
    res.back_color    = bg;
    res.segment_start = seg;
    res.end_of_line   = eol;
    res.run_last      = 1'b1;
    return res;
  endfunction

  function automatic void check_field(string name, logic [ifcp_pkg::CharW-1:0] want,
                                      logic [ifcp_pkg::CharW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  initial begin
    clear_line_state();
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Output check, config tracking and prediction, all at the rising edge
  always @(posedge clk_i) begin
    ifcp_pkg::result_t got;
    ifcp_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got               = '0;
        got.text_char     = m_axis_tdata[20:0];
        got.is_bold       = m_axis_tdata[21];
        got.is_italic     = m_axis_tdata[22];
        got.is_underline  = m_axis_tdata[23];
        got.is_reverse    = m_axis_tdata[24];
        got.fore_color    = m_axis_tdata[31:25];
        got.back_color    = m_axis_tdata[38:32];
        got.run_last      = m_axis_tdata[39];
        got.text_valid    = m_axis_tuser[0];
        got.segment_start = m_axis_tuser[1];
        got.end_of_line   = m_axis_tlast;
        if (pending_results.size() == 0) begin
          $error("result transaction with no expectation pending: tdata 0x%0h",
                 m_axis_tdata);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("text_valid", want.text_valid, got.text_valid);
          check_field("text_char", want.text_char, got.text_char);
          check_field("is_bold", want.is_bold, got.is_bold);
          check_field("is_italic", want.is_italic, got.is_italic);
          check_field("is_underline", want.is_underline, got.is_underline);
          check_field("is_reverse", want.is_reverse, got.is_reverse);
          check_field("fore_color", want.fore_color, got.fore_color);
          check_field("back_color", want.back_color, got.back_color);
          check_field("segment_start", want.segment_start, got.segment_start);
          check_field("end_of_line", want.end_of_line, got.end_of_line);
          check_field("run_last", want.run_last, got.run_last);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (ifcp_pkg::cfg_idx_e'(cfg_addr_i))
          ifcp_pkg::CFG_DEFAULT_COLOR: default_cfg = cfg_data_i;
          ifcp_pkg::CFG_HIGHEST_COLOR: highest_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata[ifcp_pkg::CharW-1:0], s_axis_tlast);
        if (typed_on) begin
          pending_results.push_back(typed_res);
        end else begin
          foreach (step_q[k]) pending_results.push_back(step_q[k]);
        end
      end
    end
  end

  // Result side back-pressure with randomly chosen modes
  always @(negedge clk_i) begin
    rx_mode_e rx_mode;
    int       rx_left;
    if (rx_left <= 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_axis_tready <= ($urandom_range(0, 2) == 0);
      default:  m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Called at a falling edge; returns at a falling edge after the transaction
  task automatic send_char(logic [ifcp_pkg::CharW-1:0] ch, logic last, logic has_typed,
                           ifcp_pkg::result_t res);
    int gap;
    s_axis_tdata  = {3'b000, ch};
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    typed_on      = has_typed;
    typed_res     = res;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic write_cfg(ifcp_pkg::cfg_idx_e idx, logic [6:0] val);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // codes give no result, so let the pipeline drain a little longer
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("irc_format_code_parser test failed");
    $finish;
  end

  initial begin
    dir_row_t                   dir_tab[25];
    logic [ifcp_pkg::CharW-1:0] ctl_codes[6];
    logic [ifcp_pkg::CharW-1:0] line_chars[$];
    logic [6:0]                 def_set[NumPhases];
    logic [6:0]                 high_set[NumPhases];
    int                         items;
    int                         parts;
    int                         sel;
    int                         nd;

    ctl_codes = '{ifcp_pkg::ChBold, ifcp_pkg::ChColor, ifcp_pkg::ChPlain,
                  ifcp_pkg::ChReverse, ifcp_pkg::ChItalic, ifcp_pkg::ChUnderline};
    def_set   = '{7'd5, 7'd0, 7'd127, 7'($urandom_range(0, 127)),
                  ifcp_pkg::DefaultColorRst};
    high_set  = '{7'd99, 7'd0, 7'd99, 7'($urandom_range(0, 99)),
                  ifcp_pkg::HighestColorRst};

    dir_tab = '{
      '{21'h41, 1'b0, 1'b1, typed_result(1'b1, 21'h41, 1'b0, 1'b0, 1'b0, 1'b0,
                                         ifcp_pkg::DefaultColorRst,
                                         ifcp_pkg::DefaultColorRst, 1'b1, 1'b0)},
      '{ifcp_pkg::ChBold, 1'b0, 1'b0, '0},
      '{ifcp_pkg::ChItalic, 1'b0, 1'b0, '0},
      '{ifcp_pkg::ChUnderline, 1'b0, 1'b0, '0},
      '{ifcp_pkg::ChReverse, 1'b0, 1'b0, '0},
      '{21'h10FFFF, 1'b0, 1'b1, typed_result(1'b1, 21'h10FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                                             ifcp_pkg::DefaultColorRst,
                                             ifcp_pkg::DefaultColorRst, 1'b1, 1'b0)},
      '{ifcp_pkg::ChPlain, 1'b0, 1'b0, '0},
      // two fg digits, comma, two bg digits, then code point zero as text
      '{ifcp_pkg::ChColor, 1'b0, 1'b0, '0},
      '{21'h31, 1'b0, 1'b0, '0},
      '{21'h32, 1'b0, 1'b0, '0},
      '{ifcp_pkg::ChComma, 1'b0, 1'b0, '0},
      '{21'h30, 1'b0, 1'b0, '0},
      '{21'h35, 1'b0, 1'b0, '0},
      '{21'h00, 1'b0, 1'b0, '0},
      // out-of-range fg, then a comma with no digit behind it
      '{ifcp_pkg::ChColor, 1'b0, 1'b0, '0},
      '{21'h39, 1'b0, 1'b0, '0},
      '{21'h39, 1'b0, 1'b0, '0},
      '{ifcp_pkg::ChComma, 1'b0, 1'b0, '0},
      '{21'h78, 1'b0, 1'b0, '0},
      // bare color code
      '{ifcp_pkg::ChColor, 1'b0, 1'b0, '0},
      '{21'h41, 1'b0, 1'b0, '0},
      // held comma is the last character of the line
      '{ifcp_pkg::ChColor, 1'b0, 1'b0, '0},
      '{21'h37, 1'b0, 1'b0, '0},
      '{ifcp_pkg::ChComma, 1'b1, 1'b0, '0},
      '{ifcp_pkg::ChReverse, 1'b1, 1'b1,
        typed_result(1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1, ifcp_pkg::DefaultColorRst,
                     ifcp_pkg::DefaultColorRst, 1'b0, 1'b1)}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[r]) send_char(dir_tab[r].ch, dir_tab[r].last, dir_tab[r].typed,
                                   dir_tab[r].res);

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_cfg(ifcp_pkg::CFG_DEFAULT_COLOR, def_set[ph]);
      write_cfg(ifcp_pkg::CFG_HIGHEST_COLOR, high_set[ph]);
      items = 0;
      while (items < PhaseItems) begin
        line_chars.delete();
        if ($urandom_range(0, 19) == 0) begin
          // noise line: anything from the low control and digit range
          repeat ($urandom_range(1, 10)) line_chars.push_back(21'($urandom_range(0, 8'h3F)));
        end else begin
          parts = $urandom_range(1, 6);
          repeat (parts) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
              repeat ($urandom_range(1, 3)) begin
                line_chars.push_back(21'($urandom_range(8'h20, 8'h7E)));
              end
            end else if (sel < 55) begin
              line_chars.push_back(ifcp_pkg::ChColor);
              nd = $urandom_range(0, 3);
              repeat (nd) begin
                line_chars.push_back(21'($urandom_range(ifcp_pkg::ChZero, ifcp_pkg::ChNine)));
              end
              if ($urandom_range(0, 1)) begin
                line_chars.push_back(ifcp_pkg::ChComma);
                nd = $urandom_range(0, 3);
                repeat (nd) begin
                  line_chars.push_back(
                    21'($urandom_range(ifcp_pkg::ChZero, ifcp_pkg::ChNine)));
                end
              end
            end else if (sel < 70) begin
              line_chars.push_back(ctl_codes[$urandom_range(0, 5)]);
            end else if (sel < 80) begin
              line_chars.push_back(21'($urandom_range(0, 21'h10FFFF)));
            end else if (sel < 90) begin
              line_chars.push_back($urandom_range(0, 1) ? ifcp_pkg::ChComma :
                                   21'($urandom_range(ifcp_pkg::ChZero, ifcp_pkg::ChNine)));
            end else begin
              line_chars.push_back(21'($urandom_range(0, 8'h3F)));
            end
          end
        end
        foreach (line_chars[k]) begin
          send_char(line_chars[k], k == line_chars.size() - 1, 1'b0, '0);
          items++;
        end
      end
    end

    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("irc_format_code_parser test passed");
    end else begin
      $display("irc_format_code_parser test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ifcp_pkg.sv
design/ifcp_front.sv
design/ifcp_fifo.sv
design/ifcp_back.sv
design/irc_format_code_parser.sv
tb/sv/irc_format_code_parser_test.sv
